// ===== rtl/dils_pkg.sv =====
// ----------------------------------------------------------------------------
// dils_pkg: shared types and constants for the init list sequencer
// word widths, result kinds and the long-delay code
// ----------------------------------------------------------------------------
`default_nettype none

package dils_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ValueW = 9;

  typedef enum logic [KindW-1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_WAIT  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  // delay byte of all ones stands for the long wait
  localparam logic [ByteW-1:0]  DELAY_MAX_CODE = 8'd255;
  localparam logic [ValueW-1:0] DELAY_MAX_MS   = 9'd500;

  typedef struct packed {
    kind_t             kind;
    logic [ValueW-1:0] value;
    logic              ends_command;
    logic              ends_list;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dils_stream_if.sv =====
// ----------------------------------------------------------------------------
// dils stream interfaces: list byte channel and result channel
// valid/ready handshake, a word moves when both are high at a clock edge
// ----------------------------------------------------------------------------
`default_nettype none

interface dils_in_if;
  logic                       valid;
  logic                       ready;
  logic [dils_pkg::ByteW-1:0] list_byte;

  modport source (output valid, output list_byte, input ready);
  modport sink   (input valid, input list_byte, output ready);
endinterface

interface dils_out_if;
  logic                        valid;
  logic                        ready;
  logic [dils_pkg::KindW-1:0]  kind;
  logic [dils_pkg::ValueW-1:0] value;
  logic                        ends_command;
  logic                        ends_list;

  modport source (output valid, output kind, output value, output ends_command,
                  output ends_list, input ready);
  modport sink   (input valid, input kind, input value, input ends_command,
                  input ends_list, output ready);
endinterface

`default_nettype wire

// ===== rtl/display_init_list_sequencer.sv =====
// ----------------------------------------------------------------------------
// display_init_list_sequencer: panel init command list interpreter
// Usage:
//   in_list takes the list one byte per word: command count, then for each
//   command the command byte, the argument byte (bit 7 asks for a delay,
//   bits 6..0 give the argument count), the data bytes and an optional
//   delay byte (all ones means 500 ms).
//   out_result gives at most one word per list byte: the command byte (sent
//   with d/c low) once its argument byte is in, each data byte, the wait
//   request, or an empty-list marker for a count of zero. ends_command marks
//   chip-select release, ends_list the last word of the list.
//   Result: a result is registered, in the result register or, while the receiver stalls, in the skid word.
//   Throughput: one list byte per cycle while in_list.ready is high; the whole step is one small state
//   update between the input handshake and the result register.
//   Stall: a two-word output stage (result register plus skid) keeps
//   in_list.ready high while one result waits; ready drops only when both
//   words are held.
//   Reset: rst_n low at a rising clock edge returns to awaiting a command count and
//   drops both output words.
// ----------------------------------------------------------------------------
`default_nettype none

module display_init_list_sequencer (
  input  wire logic clk,
  input  wire logic rst_n,
  dils_in_if.sink   in_list,
  dils_out_if.source out_result
);

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_CMD   = 3'd1,
    PH_ARGB  = 3'd2,
    PH_DATA  = 3'd3,
    PH_DELAY = 3'd4
  } phase_t;

  // list walking state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmds_left_r, cmds_left_nxt;
  logic [6:0]  args_left_r, args_left_nxt;
  logic        delay_r, delay_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;

  // output stage: result register plus skid word
  dils_pkg::result_t out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r, res_valid;

  logic       in_acc;
  logic       out_take;
  logic       last_cmd;
  logic [7:0] b;
  logic [6:0] arg_cnt;
  logic [6:0] args_dec;
  logic [7:0] cmds_dec;

  assign in_list.ready = !skid_valid_r;
  assign in_acc        = in_list.valid && !skid_valid_r;
  assign out_take      = out_valid_r && out_result.ready;

  assign b        = in_list.list_byte;
  assign last_cmd = (cmds_left_r == 8'd1);
  assign arg_cnt  = b[6:0];
  assign args_dec = args_left_r - 7'd1;
  assign cmds_dec = cmds_left_r - 8'd1;

  // one step of the list interpreter for the word being taken
  always_comb begin
    phase_nxt     = phase_r;
    cmds_left_nxt = cmds_left_r;
    args_left_nxt = args_left_r;
    delay_nxt     = delay_r;
    held_cmd_nxt  = held_cmd_r;
    res_valid     = 1'b0;
    res           = '0;
    if (in_acc) begin
      case (phase_r)
        PH_CMD: begin
          held_cmd_nxt = b;
          phase_nxt    = PH_ARGB;
        end
        PH_ARGB: begin
          args_left_nxt    = arg_cnt;
          delay_nxt        = b[7];
          res_valid        = 1'b1;
          res.kind         = dils_pkg::KIND_CMD;
          res.value        = {1'b0, held_cmd_r};
          res.ends_command = (arg_cnt == 7'd0);
          res.ends_list    = (arg_cnt == 7'd0) && !b[7] && last_cmd;
          if (arg_cnt != 7'd0) begin
            phase_nxt = PH_DATA;
          end else if (b[7]) begin
            phase_nxt = PH_DELAY;
          end else begin
            cmds_left_nxt = cmds_dec;
            phase_nxt     = (cmds_dec == 8'd0) ? PH_COUNT : PH_CMD;
          end
        end
        PH_DATA: begin
          args_left_nxt    = args_dec;
          res_valid        = 1'b1;
          res.kind         = dils_pkg::KIND_DATA;
          res.value        = {1'b0, b};
          res.ends_command = (args_dec == 7'd0);
          res.ends_list    = (args_dec == 7'd0) && !delay_r && last_cmd;
          if (args_dec == 7'd0) begin
            if (delay_r) begin
              phase_nxt = PH_DELAY;
            end else begin
              cmds_left_nxt = cmds_dec;
              phase_nxt     = (cmds_dec == 8'd0) ? PH_COUNT : PH_CMD;
            end
          end
        end
        PH_DELAY: begin
          res_valid        = 1'b1;
          res.kind         = dils_pkg::KIND_WAIT;
          res.value        = (b == dils_pkg::DELAY_MAX_CODE) ? dils_pkg::DELAY_MAX_MS
                                                             : {1'b0, b};
          res.ends_command = 1'b0;
          res.ends_list    = last_cmd;
          cmds_left_nxt    = cmds_dec;
          phase_nxt        = (cmds_dec == 8'd0) ? PH_COUNT : PH_CMD;
        end
        default: begin
          // command count, also taken on any stray phase code
          cmds_left_nxt = b;
          if (b == 8'd0) begin
            phase_nxt        = PH_COUNT;
            res_valid        = 1'b1;
            res.kind         = dils_pkg::KIND_EMPTY;
            res.value        = '0;
            res.ends_command = 1'b0;
            res.ends_list    = 1'b1;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      cmds_left_r  <= '0;
      args_left_r  <= '0;
      delay_r      <= 1'b0;
      held_cmd_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cmds_left_r <= cmds_left_nxt;
      args_left_r <= args_left_nxt;
      delay_r     <= delay_nxt;
      held_cmd_r  <= held_cmd_nxt;
      if (!out_valid_r || out_take) begin
        // result register free this cycle: skid word first, else new result
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_r       <= res;
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        // receiver stalled: park the new result in the skid word
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.kind         = out_r.kind;
  assign out_result.value        = out_r.value;
  assign out_result.ends_command = out_r.ends_command;
  assign out_result.ends_list    = out_r.ends_list;

endmodule

`default_nettype wire
